@@ rtl/index_allocation_tracker_unit_defines.svh @@
// Assertion macros for the checker file of the index allocation tracker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef INDEX_ALLOCATION_TRACKER_UNIT_DEFINES_SVH
`define INDEX_ALLOCATION_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IAT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("index allocation tracker: assertion failed");

// Next-cycle implication, disabled during reset.
`define IAT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("index allocation tracker: assertion failed");

`endif

@@ rtl/iat_pkg.sv @@
// Package of the index allocation tracker: sizes, opcodes and status codes.
// Used by the interfaces, the RTL modules other than the RAM, and the checker.
`default_nettype none

package iat_pkg;

  // Bitmap geometry: the used map is kept as rows of WORD_W bits.
  localparam int DEPTH   = 1024;
  localparam int WORD_W  = 32;
  localparam int ROWS    = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_W   = $clog2(WORD_W);

  // Field widths.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int CUR_W   = 11;
  localparam int STAT_W  = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CUR_W-1:0] DEPTH_CUR       = CUR_W'(DEPTH);
  localparam logic [CUR_W-1:0] MAX_INDEX_RESET = 11'd1024;

  // Register indexes (paddr[2]).
  localparam logic REG_MAX_INDEX = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_CLAIM      = 2'd0,
    OP_CLAIM_AUTO = 2'd1,
    OP_ADVANCE    = 2'd2,
    OP_PRELOAD    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ rtl/iat_if.sv @@
// Valid/ready channel interfaces of the index allocation tracker.
// Depends on iat_pkg for the field widths.
`default_nettype none

// Request channel: one word is an opcode and an index.
interface iat_in_if;
  logic                      valid;
  logic                      ready;
  logic [iat_pkg::OP_W-1:0]  opcode;
  logic [iat_pkg::IDX_W-1:0] index;

  modport source (output valid, output opcode, output index, input ready);
  modport sink   (input valid, input opcode, input index, output ready);
endinterface

// Result channel: one word per request.
interface iat_out_if;
  logic                       valid;
  logic                       ready;
  logic [iat_pkg::STAT_W-1:0] status;
  logic [iat_pkg::IDX_W-1:0]  index_out;
  logic [iat_pkg::CUR_W-1:0]  cursor;
  logic                       has_gaps;

  modport source (output valid, output status, output index_out, output cursor,
                  output has_gaps, input ready);
  modport sink   (input valid, input status, input index_out, input cursor,
                  input has_gaps, output ready);
endinterface

`default_nettype wire

@@ rtl/iat_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module iat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/iat_cfg.sv @@
// APB-style configuration register file of the index allocation tracker.
// Holds the max_index limit; depends on iat_pkg.
`default_nettype none

module iat_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [iat_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [iat_pkg::PDATA_W-1:0]   pwdata,
  output logic      [iat_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [iat_pkg::CUR_W-1:0]     max_index
);
  import iat_pkg::*;

  logic wr_en;

  // A write lands in the access phase; only the first register exists.
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_INDEX);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_index <= MAX_INDEX_RESET;
    end else if (wr_en) begin
      max_index <= pwdata[CUR_W-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_INDEX) begin
      prdata = PDATA_W'(max_index);
    end
  end

endmodule

`default_nettype wire

@@ rtl/iat_zero_find.sv @@
// Finds the lowest clear bit of a bitmap row at or above a start offset.
// Depends on iat_pkg.
`default_nettype none

module iat_zero_find (
  input  wire logic [iat_pkg::WORD_W-1:0] word,
  input  wire logic [iat_pkg::BIT_W-1:0]  offset,
  output logic                            found,
  output logic      [iat_pkg::BIT_W-1:0]  pos
);
  import iat_pkg::*;

  logic [WORD_W-1:0] free_bits;

  // Free positions at or above the offset.
  assign free_bits = ~word & ({WORD_W{1'b1}} << offset);
  assign found     = |free_bits;

  // Priority encode, lowest position wins.
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/index_allocation_tracker_unit.sv @@
// Index allocation tracker: a bitmap of used indices with an automatic cursor.
//
// Channels: in_ch takes request words (opcode, index); out_ch returns one
// result word (status, index_out, cursor, has_gaps) per request, in order.
// Both use valid/ready; a word moves when valid and ready are high at a clock
// edge. The max_index limit is written over the APB-style port.
// The used map sits in a 32 x 32-bit RAM with a registered read; a request
// reads its row, modifies it and writes it back.
// Claim, claim_auto and preload pass S_IDLE (row read), S_EXEC (check and
// write-back) and S_DLVR (load of the output register). Advance stays in
// S_EXEC, scanning rows in turn up to 31 beyond its first, until it finds a
// free index or reaches the end of the map. One request is in work at a
// time; the next is accepted once the last result sits in the output register.
// Reset clears the per-row valid flags, so the whole map reads as empty at
// once, with no clearing pass; cursor, largest index and limit reset too.
// When the receiver stalls, the result holds in the output register and the
// next request finishes up to the point of delivery, then waits.
`default_nettype none

module index_allocation_tracker_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  iat_in_if.sink                            in_ch,
  iat_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [iat_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [iat_pkg::PDATA_W-1:0]  pwdata,
  output logic      [iat_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import iat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DLVR
  } state_t;

  state_t            state, state_next;
  op_t               op;
  logic [IDX_W-1:0]  idx;
  status_t           status, status_next;
  logic [CUR_W-1:0]  cursor, cursor_next;
  logic [IDX_W-1:0]  largest, largest_next;
  logic              any_used, any_used_next;
  logic [ROWS-1:0]   row_valid;
  logic              row_valid_rd;

  logic              out_valid;
  status_t           out_status;
  logic [IDX_W-1:0]  out_index;
  logic [CUR_W-1:0]  out_cursor;
  logic              out_gaps;

  logic [CUR_W-1:0]  max_index;
  logic              in_fire;
  logic              we;
  logic [ROW_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata, word;
  logic              zf_found;
  logic [BIT_W-1:0]  zf_pos;
  logic [CUR_W-1:0]  limit, idx_ext, found_cur, next_base;
  logic              idx_in_map, bit_used, load_out;

  iat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_index (max_index)
  );

  iat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  iat_zero_find u_zf (
    .word   (word),
    .offset (cursor[BIT_W-1:0]),
    .found  (zf_found),
    .pos    (zf_pos)
  );

  assign in_ch.ready      = (state == S_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.index_out = out_index;
  assign out_ch.cursor    = out_cursor;
  assign out_ch.has_gaps  = out_gaps;

  // A row never written since reset reads as all clear.
  assign word       = row_valid_rd ? rdata : '0;
  assign limit      = (max_index > DEPTH_CUR) ? DEPTH_CUR : max_index;
  assign idx_ext    = CUR_W'(idx);
  assign idx_in_map = idx_ext < DEPTH_CUR;
  assign bit_used   = idx_in_map && word[idx[BIT_W-1:0]];
  assign found_cur  = CUR_W'({cursor[CUR_W-1:BIT_W], zf_pos});
  assign next_base  = CUR_W'((cursor >> BIT_W) + CUR_W'(1)) << BIT_W;
  assign load_out   = (state == S_DLVR) && (!out_valid || out_ch.ready);

  // Sequencing: read the row, then modify and write back or keep scanning.
  always_comb begin
    state_next    = state;
    status_next   = status;
    cursor_next   = cursor;
    largest_next  = largest;
    any_used_next = any_used;
    we            = 1'b0;
    waddr         = ROW_W'(idx >> BIT_W);
    wdata         = word | (WORD_W'(1) << idx[BIT_W-1:0]);
    raddr         = ROW_W'(in_ch.index >> BIT_W);

    case (state)
      S_IDLE: begin
        if (op_t'(in_ch.opcode) == OP_ADVANCE) begin
          raddr = ROW_W'(cursor >> BIT_W);
        end
        if (in_fire) begin
          state_next  = S_EXEC;
          status_next = ST_OK;
          if (op_t'(in_ch.opcode) == OP_CLAIM) begin
            cursor_next = '0;
          end
        end
      end

      S_EXEC: begin
        raddr = ROW_W'(next_base >> BIT_W);
        if (op == OP_ADVANCE) begin
          // Scan one row per cycle for the first free index.
          if (cursor >= DEPTH_CUR) begin
            state_next = S_DLVR;
          end else if (zf_found) begin
            cursor_next = (found_cur >= DEPTH_CUR) ? DEPTH_CUR : found_cur;
            state_next  = S_DLVR;
          end else if (next_base >= DEPTH_CUR) begin
            cursor_next = DEPTH_CUR;
            state_next  = S_DLVR;
          end else begin
            cursor_next = next_base;
          end
        end else begin
          state_next = S_DLVR;
          if (op == OP_PRELOAD) begin
            if (!idx_in_map) begin
              status_next = ST_RANGE;
            end else begin
              we = 1'b1;
            end
          end else if (bit_used) begin
            status_next = ST_DUPLICATE;
          end else if (idx_ext >= limit) begin
            status_next = ST_RANGE;
          end else begin
            we = 1'b1;
          end
          if (we) begin
            any_used_next = 1'b1;
            if (!any_used || idx > largest) begin
              largest_next = idx;
            end
          end
        end
      end

      S_DLVR: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, tracker registers and the output register.
  always_ff @(posedge clk) begin
    row_valid_rd <= row_valid[raddr];
    if (in_fire) begin
      op  <= op_t'(in_ch.opcode);
      idx <= in_ch.index;
    end
    status <= status_next;
    if (load_out) begin
      out_status <= status;
      out_index  <= (op == OP_ADVANCE) ? '0 : idx;
      out_cursor <= cursor;
      out_gaps   <= any_used && (cursor < CUR_W'(largest));
    end
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      largest   <= '0;
      any_used  <= 1'b0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      largest  <= largest_next;
      any_used <= any_used_next;
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/iat_checker.sv @@
// Port-level checker of the index allocation tracker, bound to the top level.
// Depends on iat_pkg and index_allocation_tracker_unit_defines.svh.
`default_nettype none
`include "index_allocation_tracker_unit_defines.svh"

module iat_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [iat_pkg::STAT_W-1:0]  status,
  input wire logic [iat_pkg::IDX_W-1:0]   index_out,
  input wire logic [iat_pkg::CUR_W-1:0]   cursor,
  input wire logic                        has_gaps
);
  import iat_pkg::*;

  // A stalled result word holds its value.
  `IAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(index_out) && $stable(cursor) && $stable(has_gaps))

  // Only defined status codes are reported.
  `IAT_ASSERT_IMPL(a_status_code, out_valid, status == ST_OK || status == ST_DUPLICATE || status == ST_RANGE)

  // The cursor never passes the end of the map.
  `IAT_ASSERT_IMPL(a_cursor_bound, out_valid, cursor <= DEPTH_CUR)

  // A gap means the cursor lies below some used index.
  `IAT_ASSERT_IMPL(a_gap_cursor, out_valid && has_gaps, cursor < CUR_W'(DEPTH - 1))

endmodule

bind index_allocation_tracker_unit iat_checker u_iat_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .index_out (out_ch.index_out),
  .cursor    (out_ch.cursor),
  .has_gaps  (out_ch.has_gaps)
);

`default_nettype wire
